[sv/dga_pkg.sv]
// ----------------------------------------------------------------------------
// Gregorian date unit package
// Shared field widths, mode codes, calendar constants and the result word
// layout used by the date conversion sequencer and the top level.
// ----------------------------------------------------------------------------
package dga_pkg;

   // Defaults for the top-level parameters.
   localparam int MAX_YEAR_DEF    = 9999;
   localparam int OFFSET_BITS_DEF = 16;
   localparam int SER_W_DEF       = 22;

   // Field widths of the request and response words.
   localparam int MODE_W = 2;
   localparam int DAY_W  = 5;
   localparam int MON_W  = 4;
   localparam int YEAR_W = 14;
   localparam int DIST_W = 22;

   // Width of the step counter of the sequencer, and of the quotient of the
   // four-year level.
   localparam int STEP_W = 4;
   localparam int Q4_W   = 5;

   // Fixed response word: five fields packed from bit 0 up, padded to bytes.
   localparam int RSP_FIELDS_W = DAY_W + MON_W + YEAR_W + DIST_W + 1;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;

   // Calendar constants: years and days in each level of the cycle.
   localparam int YEARS_400     = 400;
   localparam int YEARS_100     = 100;
   localparam int YEARS_4       = 4;
   localparam int YEARS_1       = 1;
   localparam int CYC400_DAYS   = 146097;
   localparam int CYC100_DAYS   = 36524;
   localparam int CYC4_DAYS     = 1461;
   localparam int YEAR_DAYS     = 365;
   localparam int MONTH_STEPS   = 11;

   localparam logic [MON_W-1:0] MONTH_FIRST = 4'd1;
   localparam logic [MON_W-1:0] MONTH_LAST  = 4'd12;
   localparam logic [MON_W-1:0] MONTH_FEB   = 4'd2;
   localparam logic [MON_W-1:0] MONTH_APR   = 4'd4;
   localparam logic [MON_W-1:0] MONTH_JUN   = 4'd6;
   localparam logic [MON_W-1:0] MONTH_SEP   = 4'd9;
   localparam logic [MON_W-1:0] MONTH_NOV   = 4'd11;

   // Counts that mark a leap year: a full set of three at the one-year and
   // hundred-year levels, and the last four-year group of a century.
   localparam logic [1:0]      Q_FULL     = 2'd3;
   localparam logic [Q4_W-1:0] Q4_CENTURY = 5'd24;

   typedef enum logic [MODE_W-1:0] {
      MODE_ADD  = 2'd0,
      MODE_SUB  = 2'd1,
      MODE_DIST = 2'd2,
      MODE_NONE = 2'd3
   } mode_type;

   // Response word, first member in the highest bits.
   typedef struct packed {
      logic              out_of_range;
      logic [DIST_W-1:0] distance;
      logic [YEAR_W-1:0] result_year;
      logic [MON_W-1:0]  result_month;
      logic [DAY_W-1:0]  result_day;
   } rsp_word_type;

   // Length of a month, with February depending on the leap flag.
   function automatic logic [DAY_W-1:0] days_in_month(input logic [MON_W-1:0] month,
                                                      input logic leap);
      logic [DAY_W-1:0] len;
      case (month)
         MONTH_FEB: begin
            len = leap ? 5'd29 : 5'd28;
         end
         MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: begin
            len = 5'd30;
         end
         default: begin
            len = 5'd31;
         end
      endcase
      return len;
   endfunction

endpackage

[sv/dga_step_unit.sv]
// ----------------------------------------------------------------------------
// Date unit shared step
// One trial subtraction on the remainder lane and one addition on the
// accumulator lane: when enabled and the remainder covers the divisor, the
// divisor is taken off and the weight is added. Every conversion step, the
// offset step, the range checks and the distance all run through here.
// ----------------------------------------------------------------------------
module dga_step_unit #(
   parameter int UW = dga_pkg::SER_W_DEF
) (
   input  logic          en,
   input  logic [UW-1:0] rem,
   input  logic [UW-1:0] divisor,
   input  logic [UW-1:0] weight,
   input  logic [UW-1:0] acc,
   output logic          take,
   output logic [UW-1:0] rem_out,
   output logic [UW-1:0] acc_out
);

   logic [UW:0] diff;

   // Trial subtraction; the top bit is the borrow.
   assign diff = {1'b0, rem} - {1'b0, divisor};
   assign take = en & ~diff[UW];

   // Commit both lanes only when the step is taken.
   assign rem_out = take ? diff[UW-1:0] : rem;
   assign acc_out = take ? (acc + weight) : acc;

endmodule

[sv/dga_ctrl.sv]
// ----------------------------------------------------------------------------
// Date unit sequencer
// Captures a command word, converts dates to serial day numbers and back
// through the shared step unit, applies the offset with range clamping, or
// forms the distance between two dates.
// ----------------------------------------------------------------------------
module dga_ctrl #(
   parameter int MAX_YEAR    = dga_pkg::MAX_YEAR_DEF,
   parameter int OFFSET_BITS = dga_pkg::OFFSET_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [dga_pkg::MODE_W-1:0] req_mode,
   input  logic [dga_pkg::DAY_W-1:0]  req_day,
   input  logic [dga_pkg::MON_W-1:0]  req_month,
   input  logic [dga_pkg::YEAR_W-1:0] req_year,
   input  logic [OFFSET_BITS-1:0]     req_offset,
   input  logic [dga_pkg::DAY_W-1:0]  req_other_day,
   input  logic [dga_pkg::MON_W-1:0]  req_other_month,
   input  logic [dga_pkg::YEAR_W-1:0] req_other_year,
   output logic                       res_valid,
   input  logic                       res_ready,
   output dga_pkg::rsp_word_type      res
);

   // Serial numbers, offsets and shifted constants all fit in UW bits.
   localparam int UW    = $clog2(MAX_YEAR * 366 + 2 ** OFFSET_BITS + 1);
   localparam int YW    = $clog2(MAX_YEAR + 1);
   localparam int KB    = $clog2(MAX_YEAR / dga_pkg::YEARS_400 + 1);
   localparam int NLAST = MAX_YEAR - 1;
   localparam int TOP_SERIAL = MAX_YEAR * dga_pkg::YEAR_DAYS + NLAST / 4 - NLAST / 100
                               + NLAST / 400;
   localparam int DWIDE = UW + dga_pkg::DIST_W;

   typedef enum logic [13:0] {
      S_IDLE  = 14'b00_0000_0000_0001,
      S_LOAD  = 14'b00_0000_0000_0010,
      S_BIG   = 14'b00_0000_0000_0100,
      S_C100  = 14'b00_0000_0000_1000,
      S_C4    = 14'b00_0000_0001_0000,
      S_C1    = 14'b00_0000_0010_0000,
      S_MON   = 14'b00_0000_0100_0000,
      S_DAY   = 14'b00_0000_1000_0000,
      S_OFS   = 14'b00_0001_0000_0000,
      S_DEC   = 14'b00_0010_0000_0000,
      S_TOP   = 14'b00_0100_0000_0000,
      S_DIFF1 = 14'b00_1000_0000_0000,
      S_DIFF2 = 14'b01_0000_0000_0000,
      S_DONE  = 14'b10_0000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // Captured command word.
   dga_pkg::mode_type          mode_ff, mode_in;
   logic [dga_pkg::DAY_W-1:0]  day_ff, day_in, oday_ff, oday_in;
   logic [dga_pkg::MON_W-1:0]  mon_ff, mon_in, omon_ff, omon_in;
   logic [dga_pkg::YEAR_W-1:0] year_ff, year_in, oyear_ff, oyear_in;
   logic [OFFSET_BITS-1:0]     off_ff, off_in;

   // Working state of the conversion.
   logic                       second_ff, second_in;
   logic                       rev_ff, rev_in;
   logic                       oor_ff, oor_in;
   logic [dga_pkg::STEP_W-1:0] k_ff, k_in;
   logic [1:0]                 q100_ff, q100_in;
   logic [dga_pkg::Q4_W-1:0]   q4_ff, q4_in;
   logic [1:0]                 q1_ff, q1_in;
   logic [dga_pkg::MON_W-1:0]  mo_ff, mo_in;
   logic [UW-1:0]              r_ff, r_in, acc_ff, acc_in, save_ff, save_in;

   // Step unit operands and results.
   logic          u_en, u_take;
   logic [UW-1:0] u_r, u_d, u_c, u_acc, u_r_out, u_acc_out;

   logic [dga_pkg::DAY_W-1:0]  sel_day, dim;
   logic [dga_pkg::MON_W-1:0]  sel_mon, mon_clamp;
   logic [dga_pkg::YEAR_W-1:0] sel_year;
   logic [YW-1:0]              yc;
   logic [UW-1:0]              n_load;
   logic                       leap;
   int                         big_d, big_c, mid_d, mid_c, quad_d, quad_c, one_d, one_c;
   logic [DWIDE-1:0]           r_wide;

   dga_step_unit #(
      .UW(UW)
   ) u_step (
      .en      (u_en),
      .rem     (u_r),
      .divisor (u_d),
      .weight  (u_c),
      .acc     (u_acc),
      .take    (u_take),
      .rem_out (u_r_out),
      .acc_out (u_acc_out)
   );

   // Date being converted, with month and year clamped into range.
   always_comb begin
      sel_day  = second_ff ? oday_ff : day_ff;
      sel_mon  = second_ff ? omon_ff : mon_ff;
      sel_year = second_ff ? oyear_ff : year_ff;
      if (sel_mon == '0) begin
         mon_clamp = dga_pkg::MONTH_FIRST;
      end else if (sel_mon > dga_pkg::MONTH_LAST) begin
         mon_clamp = dga_pkg::MONTH_LAST;
      end else begin
         mon_clamp = sel_mon;
      end
      if (sel_year == '0) begin
         yc = YW'(1);
      end else if (32'(sel_year) > MAX_YEAR) begin
         yc = YW'(MAX_YEAR);
      end else begin
         yc = YW'(sel_year);
      end
      n_load = UW'(yc - YW'(1));
   end

   // Leap year from the quotient counts, valid once the year is decomposed.
   assign leap = (q1_ff == dga_pkg::Q_FULL) &&
                 ((q4_ff != dga_pkg::Q4_CENTURY) || (q100_ff == dga_pkg::Q_FULL));
   assign dim  = dga_pkg::days_in_month(mo_ff, leap);

   // Divisors and weights swap roles between date-to-serial and back.
   always_comb begin
      if (rev_ff) begin
         big_d  = dga_pkg::CYC400_DAYS;
         big_c  = dga_pkg::YEARS_400;
         mid_d  = dga_pkg::CYC100_DAYS;
         mid_c  = dga_pkg::YEARS_100;
         quad_d = dga_pkg::CYC4_DAYS;
         quad_c = dga_pkg::YEARS_4;
         one_d  = dga_pkg::YEAR_DAYS;
         one_c  = dga_pkg::YEARS_1;
      end else begin
         big_d  = dga_pkg::YEARS_400;
         big_c  = dga_pkg::CYC400_DAYS;
         mid_d  = dga_pkg::YEARS_100;
         mid_c  = dga_pkg::CYC100_DAYS;
         quad_d = dga_pkg::YEARS_4;
         quad_c = dga_pkg::CYC4_DAYS;
         one_d  = dga_pkg::YEARS_1;
         one_c  = dga_pkg::YEAR_DAYS;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   // Sequencer: one step of the shared unit per cycle.
   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      day_in    = day_ff;
      mon_in    = mon_ff;
      year_in   = year_ff;
      off_in    = off_ff;
      oday_in   = oday_ff;
      omon_in   = omon_ff;
      oyear_in  = oyear_ff;
      second_in = second_ff;
      rev_in    = rev_ff;
      oor_in    = oor_ff;
      k_in      = k_ff;
      q100_in   = q100_ff;
      q4_in     = q4_ff;
      q1_in     = q1_ff;
      mo_in     = mo_ff;
      r_in      = r_ff;
      acc_in    = acc_ff;
      save_in   = save_ff;
      u_en      = 1'b0;
      u_r       = r_ff;
      u_d       = '0;
      u_c       = '0;
      u_acc     = acc_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mode_in   = dga_pkg::mode_type'(req_mode);
               day_in    = req_day;
               mon_in    = req_month;
               year_in   = req_year;
               off_in    = req_offset;
               oday_in   = req_other_day;
               omon_in   = req_other_month;
               oyear_in  = req_other_year;
               second_in = 1'b0;
               oor_in    = 1'b0;
               state_in  = (dga_pkg::mode_type'(req_mode) == dga_pkg::MODE_NONE) ?
                           S_DONE : S_LOAD;
            end
         end
         S_LOAD: begin
            r_in     = n_load;
            acc_in   = '0;
            rev_in   = 1'b0;
            k_in     = dga_pkg::STEP_W'(KB - 1);
            q100_in  = '0;
            q4_in    = '0;
            q1_in    = '0;
            mo_in    = dga_pkg::MONTH_FIRST;
            state_in = S_BIG;
         end
         S_BIG: begin
            u_en   = 1'b1;
            u_d    = UW'(big_d) << k_ff;
            u_c    = UW'(big_c) << k_ff;
            r_in   = u_r_out;
            acc_in = u_acc_out;
            if (k_ff == '0) begin
               k_in     = dga_pkg::STEP_W'(2);
               state_in = S_C100;
            end else begin
               k_in = k_ff - dga_pkg::STEP_W'(1);
            end
         end
         S_C100: begin
            u_en    = 1'b1;
            u_d     = UW'(mid_d);
            u_c     = UW'(mid_c);
            r_in    = u_r_out;
            acc_in  = u_acc_out;
            q100_in = q100_ff + 2'(u_take);
            if (k_ff == '0) begin
               k_in     = dga_pkg::STEP_W'(dga_pkg::Q4_W - 1);
               state_in = S_C4;
            end else begin
               k_in = k_ff - dga_pkg::STEP_W'(1);
            end
         end
         S_C4: begin
            u_en   = 1'b1;
            u_d    = UW'(quad_d) << k_ff;
            u_c    = UW'(quad_c) << k_ff;
            r_in   = u_r_out;
            acc_in = u_acc_out;
            q4_in  = {q4_ff[dga_pkg::Q4_W-2:0], u_take};
            if (k_ff == '0) begin
               k_in     = dga_pkg::STEP_W'(2);
               state_in = S_C1;
            end else begin
               k_in = k_ff - dga_pkg::STEP_W'(1);
            end
         end
         S_C1: begin
            u_en   = 1'b1;
            u_d    = UW'(one_d);
            u_c    = UW'(one_c);
            r_in   = u_r_out;
            acc_in = u_acc_out;
            q1_in  = q1_ff + 2'(u_take);
            if (k_ff == '0) begin
               k_in     = dga_pkg::STEP_W'(dga_pkg::MONTH_STEPS - 1);
               state_in = S_MON;
            end else begin
               k_in = k_ff - dga_pkg::STEP_W'(1);
            end
         end
         S_MON: begin
            // Forward: add whole months before the given one. Back: peel months.
            u_en   = rev_ff | (mo_ff < mon_clamp);
            u_d    = rev_ff ? UW'(dim) : '0;
            u_c    = rev_ff ? '0 : UW'(dim);
            r_in   = u_r_out;
            acc_in = u_acc_out;
            mo_in  = mo_ff + dga_pkg::MON_W'(u_take);
            if (k_ff == '0) begin
               state_in = rev_ff ? S_DONE : S_DAY;
            end else begin
               k_in = k_ff - dga_pkg::STEP_W'(1);
            end
         end
         S_DAY: begin
            u_en   = 1'b1;
            u_c    = UW'(sel_day);
            acc_in = u_acc_out;
            if (mode_ff == dga_pkg::MODE_DIST) begin
               if (!second_ff) begin
                  save_in   = u_acc_out;
                  second_in = 1'b1;
                  state_in  = S_LOAD;
               end else begin
                  state_in = S_DIFF1;
               end
            end else begin
               state_in = S_OFS;
            end
         end
         S_OFS: begin
            // Subtract takes off offset plus one, giving the zero-based day.
            u_en = 1'b1;
            u_r  = acc_ff;
            if (mode_ff == dga_pkg::MODE_SUB) begin
               u_d = UW'(off_ff) + UW'(1);
            end else begin
               u_c = UW'(off_ff);
            end
            r_in   = u_r_out;
            acc_in = u_acc_out;
            if (!u_take) begin
               r_in     = '0;
               oor_in   = 1'b1;
               state_in = S_TOP;
            end else if (mode_ff == dga_pkg::MODE_ADD) begin
               state_in = S_DEC;
            end else begin
               state_in = S_TOP;
            end
         end
         S_DEC: begin
            u_en = 1'b1;
            u_r  = acc_ff;
            u_d  = UW'(1);
            if (u_take) begin
               r_in = u_r_out;
            end else begin
               r_in   = '0;
               oor_in = 1'b1;
            end
            state_in = S_TOP;
         end
         S_TOP: begin
            // Clamp to the last supported day, then convert back.
            u_en = 1'b1;
            u_d  = UW'(TOP_SERIAL);
            if (u_take) begin
               r_in   = UW'(TOP_SERIAL - 1);
               oor_in = 1'b1;
            end
            acc_in   = '0;
            rev_in   = 1'b1;
            k_in     = dga_pkg::STEP_W'(KB - 1);
            q100_in  = '0;
            q4_in    = '0;
            q1_in    = '0;
            mo_in    = dga_pkg::MONTH_FIRST;
            state_in = S_BIG;
         end
         S_DIFF1: begin
            u_en = 1'b1;
            u_r  = save_ff;
            u_d  = acc_ff;
            if (u_take) begin
               r_in     = u_r_out;
               state_in = S_DONE;
            end else begin
               state_in = S_DIFF2;
            end
         end
         S_DIFF2: begin
            u_en     = 1'b1;
            u_r      = acc_ff;
            u_d      = save_ff;
            r_in     = u_r_out;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result word, formed from the working registers.
   assign r_wide    = DWIDE'(r_ff);
   assign res_valid = (state_ff == S_DONE);

   always_comb begin
      res = '0;
      case (mode_ff)
         dga_pkg::MODE_ADD, dga_pkg::MODE_SUB: begin
            res.result_day   = dga_pkg::DAY_W'(r_ff) + dga_pkg::DAY_W'(1);
            res.result_month = mo_ff;
            res.result_year  = dga_pkg::YEAR_W'(acc_ff + UW'(1));
            res.out_of_range = oor_ff;
         end
         dga_pkg::MODE_DIST: begin
            res.distance = (|(r_wide >> dga_pkg::DIST_W)) ? '1 :
                           r_wide[dga_pkg::DIST_W-1:0];
         end
         default: begin
            res = '0;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Command and working registers.
   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      day_ff    <= day_in;
      mon_ff    <= mon_in;
      year_ff   <= year_in;
      off_ff    <= off_in;
      oday_ff   <= oday_in;
      omon_ff   <= omon_in;
      oyear_ff  <= oyear_in;
      second_ff <= second_in;
      rev_ff    <= rev_in;
      oor_ff    <= oor_in;
      k_ff      <= k_in;
      q100_ff   <= q100_in;
      q4_ff     <= q4_in;
      q1_ff     <= q1_in;
      mo_ff     <= mo_in;
      r_ff      <= r_in;
      acc_ff    <= acc_in;
      save_ff   <= save_in;
   end

   // The second difference step only runs when the second date is the later.
   a_diff2_take : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIFF2) |-> u_take)
      else $error("distance: second subtraction borrowed");

   // A finished date has a legal month and a day of at most 31.
   a_done_date : assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DONE) && rev_ff &&
       ((mode_ff == dga_pkg::MODE_ADD) || (mode_ff == dga_pkg::MODE_SUB))) |->
      ((mo_ff >= dga_pkg::MONTH_FIRST) && (mo_ff <= dga_pkg::MONTH_LAST) &&
       (r_ff < UW'(31))))
      else $error("conversion ended with an impossible date");

   // The year decomposition leaves less than a year for the month walk.
   a_month_walk : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MON) |-> ((q4_ff <= dga_pkg::Q4_CENTURY) && (r_ff < UW'(366))))
      else $error("year decomposition out of range");

   // An accepted command always leaves the idle state.
   a_accept : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != S_IDLE))
      else $error("accepted command was dropped");

endmodule

[sv/gregorian_date_arithmetic.sv]
// ----------------------------------------------------------------------------
// Gregorian date arithmetic
// Adds or subtracts a day count to a date, or gives the distance in days
// between two dates, on the proleptic Gregorian calendar.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on the req_ stream, one word each; req_tuser selects the
// operation (add, subtract, distance, or none, which returns a zero word).
// Each command yields exactly one word on the rsp_ stream.
// Dates are converted to serial day numbers and back by a sequencer driving
// one compare-subtract-accumulate unit, one step per cycle. Add converts the
// date forward, adds the offset and takes off one, clamps the serial to the
// supported range and converts back; subtract takes off the offset plus one
// instead. Distance converts both dates and takes the earlier from the later.
// req_tready is high only while the sequencer is idle, so a new command is not
// taken until the result of the last one has left the sequencer.
// The result sits in an output register, so the next command is accepted
// while a result waits for rsp_tready; a further result then waits in the
// sequencer until the register frees.
// Reset returns the sequencer to idle and empties the output register.
// ----------------------------------------------------------------------------
module gregorian_date_arithmetic #(
   parameter int MAX_YEAR    = dga_pkg::MAX_YEAR_DEF,
   parameter int OFFSET_BITS = dga_pkg::OFFSET_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // day, month, year, offset_days, other_day, other_month, other_year
   input  logic [((46 + OFFSET_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // mode
   input  logic [dga_pkg::MODE_W-1:0]            req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // result_day, result_month, result_year, distance, out_of_range
   output logic [dga_pkg::RSP_TDATA_W-1:0]       rsp_tdata
);

   localparam int MON_LSB   = dga_pkg::DAY_W;
   localparam int YEAR_LSB  = MON_LSB + dga_pkg::MON_W;
   localparam int OFF_LSB   = YEAR_LSB + dga_pkg::YEAR_W;
   localparam int ODAY_LSB  = OFF_LSB + OFFSET_BITS;
   localparam int OMON_LSB  = ODAY_LSB + dga_pkg::DAY_W;
   localparam int OYEAR_LSB = OMON_LSB + dga_pkg::MON_W;

   logic                  res_valid, res_ready;
   dga_pkg::rsp_word_type res;
   logic                  rsp_valid_ff, rsp_valid_in;
   dga_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   dga_ctrl #(
      .MAX_YEAR    (MAX_YEAR),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_tvalid),
      .req_ready       (req_tready),
      .req_mode        (req_tuser),
      .req_day         (req_tdata[dga_pkg::DAY_W-1:0]),
      .req_month       (req_tdata[MON_LSB +: dga_pkg::MON_W]),
      .req_year        (req_tdata[YEAR_LSB +: dga_pkg::YEAR_W]),
      .req_offset      (req_tdata[OFF_LSB +: OFFSET_BITS]),
      .req_other_day   (req_tdata[ODAY_LSB +: dga_pkg::DAY_W]),
      .req_other_month (req_tdata[OMON_LSB +: dga_pkg::MON_W]),
      .req_other_year  (req_tdata[OYEAR_LSB +: dga_pkg::YEAR_W]),
      .res_valid       (res_valid),
      .res_ready       (res_ready),
      .res             (res)
   );

   // Output register: loads when empty or being drained this cycle.
   assign res_ready = ~rsp_valid_ff | rsp_tready;

   always_comb begin
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_ready) begin
         rsp_word_in  = res;
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = dga_pkg::RSP_TDATA_W'(rsp_word_ff);

endmodule
